// ===== hw/rtl/uer_pkg.sv =====
// Package: shared types, codes and constants of the ultrasonic echo ranger.
`default_nettype none

package uer_pkg;

  localparam int unsigned WINDOW_LEN = 10;

  localparam int unsigned TIME_W    = 32;
  localparam int unsigned TEMP_W    = 15;
  localparam int unsigned TIMEOUT_W = 20;
  localparam int unsigned DIST_W    = 24;
  localparam int unsigned HEALTH_W  = 7;
  localparam int unsigned MODE_W    = 3;
  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 24;

  localparam int unsigned SPEED_W = 26;
  localparam int unsigned PROD_W  = TIME_W + SPEED_W;
  localparam int unsigned REM_W   = 18;
  localparam int unsigned LIMIT_W = DIST_W + REM_W;

  localparam logic [SPEED_W-1:0]  SPEED_BASE      = SPEED_W'(33200000);
  localparam int                  SPEED_PER_CENTI = 607;
  localparam logic [REM_W-1:0]    HALF_SCALE      = REM_W'(200000);
  localparam logic [HEALTH_W-1:0] HEALTH_MAX      = HEALTH_W'(100);

  // floor(p / 200000) = ((p >> 6) * DIST_RECIP) >> 46 for every in-range product
  localparam int unsigned DIV_SHIFT   = 6;
  localparam int unsigned QIN_W       = LIMIT_W - DIV_SHIFT;
  localparam int unsigned PART_W      = QIN_W / 2;
  localparam int unsigned PPROD_W     = 2 * PART_W;
  localparam int unsigned ACC_W       = 2 * QIN_W;
  localparam int unsigned RECIP_SHIFT = 46;
  localparam logic [QIN_W-1:0]  DIST_RECIP    = QIN_W'(64'd22517998137);
  localparam logic [PART_W-1:0] DIST_RECIP_HI = DIST_RECIP[QIN_W-1:PART_W];
  localparam logic [PART_W-1:0] DIST_RECIP_LO = DIST_RECIP[PART_W-1:0];

  localparam int unsigned DIV_STEPS = 4;
  localparam int unsigned CNT_W     = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  localparam int unsigned POS_W   = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int unsigned SUM_W   = DIST_W + $clog2(WINDOW_LEN);
  localparam int unsigned RUN_W   = $clog2(WINDOW_LEN + 4);
  localparam int unsigned RECIP_K = SUM_W + $clog2(WINDOW_LEN);
  localparam logic [63:0] RECIP_FULL = ((64'd1 << RECIP_K) + 64'(WINDOW_LEN) - 64'd1)
                                       / 64'(WINDOW_LEN);
  localparam logic [SUM_W:0] RECIP = RECIP_FULL[SUM_W:0];

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK = 2'd0,
    FUNC_RISE = 2'd1,
    FUNC_FALL = 2'd2
  } func_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_IDLE      = 3'd0,
    MODE_STARTED   = 3'd1,
    MODE_ECHO_HIGH = 3'd2,
    MODE_ECHO_DONE = 3'd3,
    MODE_ERROR     = 3'd4,
    MODE_RESTART   = 3'd5
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMEOUT    = 2'd0,
    CFG_MAX_RANGE  = 2'd1,
    CFG_HEALTH_THR = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SPEED,
    ST_MUL,
    ST_CHECK,
    ST_DIV,
    ST_UPDATE,
    ST_AVG,
    ST_FINISH
  } ctl_state_e;

  typedef struct packed {
    logic             load;
    logic             exec;
    logic             speed;
    logic             mul;
    logic             reject;
    logic             div_init;
    logic             div_step;
    logic [CNT_W-1:0] div_idx;
    logic             commit;
    logic             avg;
    logic             emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic measure;
    logic out_of_range;
    logic out_free;
  } ctl_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/uer_ctrl.sv =====
// Controller: state machine that sequences one transaction through the datapath.
`default_nettype none

module uer_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  uer_pkg::ctl_sts_t sts_i,
  output uer_pkg::ctl_cmd_t cmd_o
);

  uer_pkg::ctl_state_e           state_q, state_d;
  logic [uer_pkg::CNT_W-1:0]     cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= uer_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign in_stall_o = (state_q != uer_pkg::ST_IDLE);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      uer_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = uer_pkg::ST_EXEC;
        end
      end
      uer_pkg::ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.measure ? uer_pkg::ST_SPEED : uer_pkg::ST_FINISH;
      end
      uer_pkg::ST_SPEED: begin
        cmd_o.speed = 1'b1;
        state_d     = uer_pkg::ST_MUL;
      end
      uer_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = uer_pkg::ST_CHECK;
      end
      uer_pkg::ST_CHECK: begin
        if (sts_i.out_of_range) begin
          cmd_o.reject = 1'b1;
          state_d      = uer_pkg::ST_FINISH;
        end else begin
          cmd_o.div_init = 1'b1;
          cnt_d          = '0;
          state_d        = uer_pkg::ST_DIV;
        end
      end
      uer_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cmd_o.div_idx  = cnt_q;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == uer_pkg::CNT_W'(uer_pkg::DIV_STEPS - 1)) begin
          state_d = uer_pkg::ST_UPDATE;
        end
      end
      uer_pkg::ST_UPDATE: begin
        cmd_o.commit = 1'b1;
        state_d      = uer_pkg::ST_AVG;
      end
      uer_pkg::ST_AVG: begin
        cmd_o.avg = 1'b1;
        state_d   = uer_pkg::ST_FINISH;
      end
      uer_pkg::ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = uer_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = uer_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/uer_datapath.sv =====
// Datapath: ranging state, distance arithmetic, averaging window and result register.
`default_nettype none

module uer_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  uer_pkg::ctl_cmd_t                    cmd_i,
  output uer_pkg::ctl_sts_t                    sts_o,
  input  logic [uer_pkg::FUNC_W-1:0]           func_i,
  input  logic [uer_pkg::TIME_W-1:0]           now_us_i,
  input  logic signed [uer_pkg::TEMP_W-1:0]    temp_centi_i,
  input  logic                                 cfg_valid_i,
  input  logic [uer_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [uer_pkg::CFG_DAT_W-1:0]        cfg_data_i,
  input  logic                                 out_stall_i,
  output logic                                 out_valid_o,
  output logic                                 trigger_o,
  output logic [uer_pkg::MODE_W-1:0]           mode_o,
  output logic [uer_pkg::DIST_W-1:0]           avg_distance_um_o,
  output logic [uer_pkg::DIST_W-1:0]           last_distance_um_o,
  output logic                                 measured_o,
  output logic                                 failed_o,
  output logic                                 recalibrate_o,
  output logic [uer_pkg::HEALTH_W-1:0]         health_o,
  output logic                                 prefer_ultrasonic_o
);

  logic [uer_pkg::FUNC_W-1:0]        func_q;
  logic [uer_pkg::TIME_W-1:0]        now_q;
  logic signed [uer_pkg::TEMP_W-1:0] temp_q;

  logic [uer_pkg::TIMEOUT_W-1:0]     timeout_q;
  logic [uer_pkg::DIST_W-1:0]        max_range_q;
  logic [uer_pkg::HEALTH_W-1:0]      thr_q;

  uer_pkg::mode_e                    mode_q;
  logic [uer_pkg::TIME_W-1:0]        start_q, rise_q, fall_q, rest_q;
  logic                              armed_q;
  logic [uer_pkg::DIST_W-1:0]        win_q [uer_pkg::WINDOW_LEN];
  logic [uer_pkg::POS_W-1:0]         pos_q;
  logic [uer_pkg::SUM_W-1:0]         sum_q;
  logic [uer_pkg::RUN_W-1:0]         run_q;
  logic [uer_pkg::HEALTH_W-1:0]      health_q;
  logic                              prio_q;
  logic [uer_pkg::DIST_W-1:0]        avg_q;

  logic                              trig_q, meas_q, fail_q, recal_q;
  logic [uer_pkg::DIST_W-1:0]        last_q;

  logic [uer_pkg::SPEED_W-1:0]       speed_q;
  logic [uer_pkg::TIME_W-1:0]        width_q;
  logic [uer_pkg::LIMIT_W-1:0]       limit_q;
  logic [uer_pkg::PROD_W-1:0]        prod_q;
  logic [uer_pkg::QIN_W-1:0]         quo_in_q;
  logic [uer_pkg::ACC_W-1:0]         acc_q;

  logic                              out_valid_q;
  logic                              out_trig_q, out_meas_q, out_fail_q, out_recal_q;
  logic                              out_prio_q;
  logic [uer_pkg::MODE_W-1:0]        out_mode_q;
  logic [uer_pkg::DIST_W-1:0]        out_avg_q, out_last_q;
  logic [uer_pkg::HEALTH_W-1:0]      out_health_q;

  logic [uer_pkg::TIME_W-1:0]        since_start, since_rest;
  logic [uer_pkg::TIME_W-1:0]        timeout_ext;
  logic [uer_pkg::HEALTH_W-1:0]      health_inc, health_dec;
  logic signed [uer_pkg::SPEED_W:0]  speed_calc;
  logic [2*uer_pkg::SUM_W:0]         avg_prod;
  logic [uer_pkg::POS_W-1:0]         pos_next;
  logic [uer_pkg::PART_W-1:0]        part_a, part_b;
  logic [uer_pkg::PPROD_W-1:0]       part_prod;
  logic [uer_pkg::ACC_W-1:0]         acc_base;
  logic [uer_pkg::DIST_W-1:0]        quo;

  assign since_start = now_q - start_q;
  assign since_rest  = now_q - rest_q;
  assign timeout_ext = uer_pkg::TIME_W'(timeout_q);
  assign health_inc  = (health_q < uer_pkg::HEALTH_MAX) ? health_q + 1'b1 : health_q;
  assign health_dec  = (health_q != '0) ? health_q - 1'b1 : health_q;
  assign speed_calc  = $signed({1'b0, uer_pkg::SPEED_BASE})
                     + $signed((uer_pkg::SPEED_W + 1)'(temp_q))
                     * $signed((uer_pkg::SPEED_W + 1)'(uer_pkg::SPEED_PER_CENTI));
  assign avg_prod    = (2 * uer_pkg::SUM_W + 1)'(sum_q)
                     * (2 * uer_pkg::SUM_W + 1)'(uer_pkg::RECIP);
  assign pos_next    = (pos_q == uer_pkg::POS_W'(uer_pkg::WINDOW_LEN - 1)) ? '0
                                                                          : pos_q + 1'b1;

  assign part_a    = cmd_i.div_idx[1] ? quo_in_q[uer_pkg::PART_W-1:0]
                                      : quo_in_q[uer_pkg::QIN_W-1:uer_pkg::PART_W];
  assign part_b    = cmd_i.div_idx[0] ? uer_pkg::DIST_RECIP_LO : uer_pkg::DIST_RECIP_HI;
  assign part_prod = uer_pkg::PPROD_W'(part_a) * uer_pkg::PPROD_W'(part_b);
  assign acc_base  = cmd_i.div_idx[0] ? (acc_q << uer_pkg::PART_W) : acc_q;
  assign quo       = acc_q[uer_pkg::RECIP_SHIFT+uer_pkg::DIST_W-1:uer_pkg::RECIP_SHIFT];

  assign sts_o.measure      = (func_q == uer_pkg::FUNC_TICK)
                           && (mode_q == uer_pkg::MODE_ECHO_DONE);
  assign sts_o.out_of_range = (prod_q > uer_pkg::PROD_W'(limit_q));
  assign sts_o.out_free     = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      now_q  <= now_us_i;
      temp_q <= temp_centi_i;
    end
    if (cmd_i.speed) begin
      speed_q <= uer_pkg::SPEED_W'(speed_calc);
      width_q <= fall_q - rise_q;
      limit_q <= uer_pkg::LIMIT_W'(max_range_q) * uer_pkg::LIMIT_W'(uer_pkg::HALF_SCALE);
    end
    if (cmd_i.mul) begin
      prod_q <= uer_pkg::PROD_W'(width_q) * uer_pkg::PROD_W'(speed_q);
    end
    if (cmd_i.div_init) begin
      quo_in_q <= prod_q[uer_pkg::LIMIT_W-1:uer_pkg::DIV_SHIFT];
      acc_q    <= '0;
    end else if (cmd_i.div_step) begin
      acc_q <= acc_base + uer_pkg::ACC_W'(part_prod);
    end
    if (cmd_i.emit) begin
      out_trig_q   <= trig_q;
      out_mode_q   <= mode_q;
      out_avg_q    <= avg_q;
      out_last_q   <= last_q;
      out_meas_q   <= meas_q;
      out_fail_q   <= fail_q;
      out_recal_q  <= recal_q;
      out_health_q <= health_q;
      out_prio_q   <= prio_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q   <= uer_pkg::TIMEOUT_W'(29411);
      max_range_q <= uer_pkg::DIST_W'(5000000);
      thr_q       <= uer_pkg::HEALTH_W'(90);
      mode_q      <= uer_pkg::MODE_IDLE;
      start_q     <= '0;
      rise_q      <= '0;
      fall_q      <= '0;
      rest_q      <= '0;
      armed_q     <= 1'b0;
      for (int i = 0; i < uer_pkg::WINDOW_LEN; i++) begin
        win_q[i] <= '0;
      end
      pos_q       <= '0;
      sum_q       <= '0;
      run_q       <= '0;
      health_q    <= '0;
      prio_q      <= 1'b0;
      avg_q       <= '0;
      trig_q      <= 1'b0;
      meas_q      <= 1'b0;
      fail_q      <= 1'b0;
      recal_q     <= 1'b0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (uer_pkg::cfg_idx_e'(cfg_index_i))
          uer_pkg::CFG_TIMEOUT:    timeout_q   <= cfg_data_i[uer_pkg::TIMEOUT_W-1:0];
          uer_pkg::CFG_MAX_RANGE:  max_range_q <= cfg_data_i[uer_pkg::DIST_W-1:0];
          uer_pkg::CFG_HEALTH_THR: thr_q       <= cfg_data_i[uer_pkg::HEALTH_W-1:0];
          default: ;
        endcase
      end

      if (cmd_i.exec) begin
        trig_q  <= 1'b0;
        meas_q  <= 1'b0;
        fail_q  <= 1'b0;
        recal_q <= 1'b0;
        last_q  <= '0;
        unique case (uer_pkg::func_e'(func_q))
          uer_pkg::FUNC_RISE: begin
            rise_q <= now_q;
            mode_q <= uer_pkg::MODE_ECHO_HIGH;
          end
          uer_pkg::FUNC_FALL: begin
            fall_q <= now_q;
            mode_q <= uer_pkg::MODE_ECHO_DONE;
          end
          uer_pkg::FUNC_TICK: begin
            unique case (mode_q) inside
              uer_pkg::MODE_STARTED, uer_pkg::MODE_ECHO_HIGH: begin
                if (since_start > timeout_ext) begin
                  mode_q <= uer_pkg::MODE_ERROR;
                end
              end
              uer_pkg::MODE_ECHO_DONE: ;
              uer_pkg::MODE_ERROR: begin
                run_q    <= '0;
                mode_q   <= uer_pkg::MODE_IDLE;
                health_q <= health_dec;
                if (health_dec < thr_q) begin
                  prio_q <= 1'b0;
                end
                fail_q   <= 1'b1;
              end
              uer_pkg::MODE_IDLE: begin
                if (!armed_q) begin
                  rest_q  <= now_q;
                  armed_q <= 1'b1;
                end else if (since_rest > timeout_ext) begin
                  mode_q  <= uer_pkg::MODE_RESTART;
                  armed_q <= 1'b0;
                end
              end
              default: begin
                trig_q  <= 1'b1;
                start_q <= now_q;
                mode_q  <= uer_pkg::MODE_STARTED;
              end
            endcase
          end
          default: ;
        endcase
      end

      if (cmd_i.reject) begin
        mode_q <= uer_pkg::MODE_ERROR;
      end

      if (cmd_i.commit) begin
        sum_q        <= sum_q - uer_pkg::SUM_W'(win_q[pos_q]) + uer_pkg::SUM_W'(quo);
        win_q[pos_q] <= quo;
        pos_q        <= pos_next;
        if (run_q > uer_pkg::RUN_W'(uer_pkg::WINDOW_LEN + 2)) begin
          recal_q <= 1'b1;
          run_q   <= uer_pkg::RUN_W'(uer_pkg::WINDOW_LEN);
        end else begin
          run_q   <= run_q + 1'b1;
        end
        health_q <= health_inc;
        prio_q   <= (health_inc > thr_q);
        meas_q   <= 1'b1;
        last_q   <= quo;
        mode_q   <= uer_pkg::MODE_IDLE;
      end

      if (cmd_i.avg) begin
        avg_q <= uer_pkg::DIST_W'(avg_prod >> uer_pkg::RECIP_K);
      end

      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o         = out_valid_q;
  assign trigger_o           = out_trig_q;
  assign mode_o              = out_mode_q;
  assign avg_distance_um_o   = out_avg_q;
  assign last_distance_um_o  = out_last_q;
  assign measured_o          = out_meas_q;
  assign failed_o            = out_fail_q;
  assign recalibrate_o       = out_recal_q;
  assign health_o            = out_health_q;
  assign prefer_ultrasonic_o = out_prio_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ultrasonic_echo_ranger.sv =====
// Top level: ultrasonic echo ranger, controller and datapath.
//
//   channel | handshake              | payload
//   --------+------------------------+----------------------------------------------
//   in      | in_valid_i / in_stall_o | func_i, now_us_i, temp_centi_i
//   out     | out_valid_o/out_stall_i | trigger, mode, avg/last distance, flags, health
//   cfg     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// Echo edges, plain ticks and unknown codes go through load, execute and finish.
// A tick that closes a measurement adds speed, multiply, range check, four
// partial products of the reciprocal multiply for the divide by 200000, window
// update and the average multiply. An out-of-range measurement ends after the
// range check. Reset clears the ranging state and window and loads the default
// configuration at once; no clearing pass. The input stalls while an item is in
// work; a result held by out_stall_i stalls the next item only at its end.
`default_nettype none

module ultrasonic_echo_ranger (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [uer_pkg::FUNC_W-1:0]         func_i,
  input  logic [uer_pkg::TIME_W-1:0]         now_us_i,
  input  logic signed [uer_pkg::TEMP_W-1:0]  temp_centi_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               trigger_o,
  output logic [uer_pkg::MODE_W-1:0]         mode_o,
  output logic [uer_pkg::DIST_W-1:0]         avg_distance_um_o,
  output logic [uer_pkg::DIST_W-1:0]         last_distance_um_o,
  output logic                               measured_o,
  output logic                               failed_o,
  output logic                               recalibrate_o,
  output logic [uer_pkg::HEALTH_W-1:0]       health_o,
  output logic                               prefer_ultrasonic_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [uer_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [uer_pkg::CFG_DAT_W-1:0]      cfg_data_i
);

  uer_pkg::ctl_cmd_t cmd;
  uer_pkg::ctl_sts_t sts;

  assign cfg_ready_o = 1'b1;

  uer_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  uer_datapath u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .func_i              (func_i),
    .now_us_i            (now_us_i),
    .temp_centi_i        (temp_centi_i),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .out_stall_i         (out_stall_i),
    .out_valid_o         (out_valid_o),
    .trigger_o           (trigger_o),
    .mode_o              (mode_o),
    .avg_distance_um_o   (avg_distance_um_o),
    .last_distance_um_o  (last_distance_um_o),
    .measured_o          (measured_o),
    .failed_o            (failed_o),
    .recalibrate_o       (recalibrate_o),
    .health_o            (health_o),
    .prefer_ultrasonic_o (prefer_ultrasonic_o)
  );

endmodule

`default_nettype wire

// ===== verif/ultrasonic_echo_ranger_checker.sv =====
// Checker: predicts each ranger result from accepted transactions and compares them.
module ultrasonic_echo_ranger_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic [uer_pkg::FUNC_W-1:0]        func_i,
  input  logic [uer_pkg::TIME_W-1:0]        now_us_i,
  input  logic signed [uer_pkg::TEMP_W-1:0] temp_centi_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic                              trigger_i,
  input  logic [uer_pkg::MODE_W-1:0]        mode_i,
  input  logic [uer_pkg::DIST_W-1:0]        avg_distance_um_i,
  input  logic [uer_pkg::DIST_W-1:0]        last_distance_um_i,
  input  logic                              measured_i,
  input  logic                              failed_i,
  input  logic                              recalibrate_i,
  input  logic [uer_pkg::HEALTH_W-1:0]      health_i,
  input  logic                              prefer_ultrasonic_i,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_i,
  input  logic [uer_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [uer_pkg::CFG_DAT_W-1:0]     cfg_data_i,
  output int                                fail_count_o,
  output int                                pending_o,
  output int                                checked_o,
  output int                                distance_count_o,
  output int                                error_count_o,
  output int                                recal_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import uer_pkg::*;

  localparam int                SOUND_BASE  = 33200000;
  localparam int                SOUND_SLOPE = 607;
  localparam longint unsigned   UM_DIVISOR  = 200000;
  localparam int unsigned       HEALTH_CEIL = 100;

  typedef struct packed {
    logic                trigger;
    mode_e               mode;
    logic [DIST_W-1:0]   avg_um;
    logic [DIST_W-1:0]   last_um;
    logic                measured;
    logic                failed;
    logic                recal;
    logic [HEALTH_W-1:0] health;
    logic                prefer;
  } report_t;

  report_t expected_reports[$];

  logic [TIMEOUT_W-1:0] limit_us;
  logic [DIST_W-1:0]    range_um;
  logic [HEALTH_W-1:0]  thr_q;

  mode_e               mode_q;
  logic [TIME_W-1:0]   start_us;
  logic [TIME_W-1:0]   rise_us;
  logic [TIME_W-1:0]   fall_us;
  logic [TIME_W-1:0]   rest_us;
  logic                rest_armed_q;
  logic [DIST_W-1:0]   window_q[WINDOW_LEN];
  int unsigned         pos_q;
  logic [31:0]         sum_q;
  int unsigned         run_q;
  logic [HEALTH_W-1:0] health_q;
  logic                prefer_q;

  task automatic predict_ranging(input logic [FUNC_W-1:0] code, input logic [TIME_W-1:0] stamp,
                                 input logic signed [TEMP_W-1:0] temp, output report_t rep);
    logic [31:0] elapsed;
    logic [63:0] span;
    logic [63:0] prod;
    logic [63:0] bound;
    int          speed;
    rep = '0;
    case (code)
      FUNC_RISE: begin
        rise_us = stamp;
        mode_q  = MODE_ECHO_HIGH;
      end
      FUNC_FALL: begin
        fall_us = stamp;
        mode_q  = MODE_ECHO_DONE;
      end
      FUNC_TICK: begin
        case (mode_q)
          MODE_STARTED, MODE_ECHO_HIGH: begin
            elapsed = stamp - start_us;
            if (elapsed > {12'd0, limit_us}) mode_q = MODE_ERROR;
          end
          MODE_ECHO_DONE: begin
            span  = {32'd0, fall_us - rise_us};
            speed = SOUND_BASE + SOUND_SLOPE * int'(temp);
            prod  = span * 64'(speed);
            bound = 64'(range_um) * UM_DIVISOR;
            if (prod > bound) begin
              mode_q = MODE_ERROR;
            end else begin
              rep.last_um     = DIST_W'(prod / UM_DIVISOR);
              sum_q           = sum_q - 32'(window_q[pos_q]) + 32'(rep.last_um);
              window_q[pos_q] = rep.last_um;
              pos_q           = (pos_q + 1) % WINDOW_LEN;
              if (run_q > WINDOW_LEN + 2) begin
                rep.recal = 1'b1;
                run_q     = WINDOW_LEN;
              end else begin
                run_q++;
              end
              if (health_q < HEALTH_CEIL) health_q++;
              prefer_q     = health_q > thr_q;
              rep.measured = 1'b1;
              mode_q       = MODE_IDLE;
            end
          end
          MODE_ERROR: begin
            run_q  = 0;
            mode_q = MODE_IDLE;
            if (health_q > 0) health_q--;
            if (health_q < thr_q) prefer_q = 1'b0;
            rep.failed = 1'b1;
          end
          MODE_IDLE: begin
            elapsed = stamp - rest_us;
            if (!rest_armed_q) begin
              rest_us      = stamp;
              rest_armed_q = 1'b1;
            end else if (elapsed > {12'd0, limit_us}) begin
              mode_q       = MODE_RESTART;
              rest_armed_q = 1'b0;
            end
          end
          default: begin
            rep.trigger = 1'b1;
            start_us    = stamp;
            mode_q      = MODE_STARTED;
          end
        endcase
      end
      default: ;
    endcase
    rep.mode   = mode_q;
    rep.avg_um = DIST_W'(sum_q / WINDOW_LEN);
    rep.health = health_q;
    rep.prefer = prefer_q;
  endtask

  task automatic compare_field(input string label, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      fail_count_o++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    report_t want;
    if (!rst_ni) begin
      limit_us     = TIMEOUT_W'(29411);
      range_um     = DIST_W'(5000000);
      thr_q        = HEALTH_W'(90);
      mode_q       = MODE_IDLE;
      start_us     = '0;
      rise_us      = '0;
      fall_us      = '0;
      rest_us      = '0;
      rest_armed_q = 1'b0;
      foreach (window_q[k]) window_q[k] = '0;
      pos_q        = 0;
      sum_q        = '0;
      run_q        = 0;
      health_q     = '0;
      prefer_q     = 1'b0;
      expected_reports.delete();
      pending_o    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_reports.size() == 0) begin
          fail_count_o++;
          $display("%0t ns: result transaction with no expectation pending", $time);
        end else begin
          want = expected_reports.pop_front();
          checked_o++;
          compare_field("trigger", 32'(want.trigger), 32'(trigger_i));
          compare_field("mode", 32'(want.mode), 32'(mode_i));
          compare_field("avg_distance_um", 32'(want.avg_um), 32'(avg_distance_um_i));
          compare_field("last_distance_um", 32'(want.last_um), 32'(last_distance_um_i));
          compare_field("measured", 32'(want.measured), 32'(measured_i));
          compare_field("failed", 32'(want.failed), 32'(failed_i));
          compare_field("recalibrate", 32'(want.recal), 32'(recalibrate_i));
          compare_field("health", 32'(want.health), 32'(health_i));
          compare_field("prefer_ultrasonic", 32'(want.prefer), 32'(prefer_ultrasonic_i));
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_TIMEOUT:    limit_us = cfg_data_i[TIMEOUT_W-1:0];
          CFG_MAX_RANGE:  range_um = cfg_data_i[DIST_W-1:0];
          CFG_HEALTH_THR: thr_q    = cfg_data_i[HEALTH_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        predict_ranging(func_i, now_us_i, temp_centi_i, want);
        expected_reports.push_back(want);
        if (want.measured) distance_count_o++;
        if (want.failed) error_count_o++;
        if (want.recal) recal_count_o++;
      end
      pending_o = expected_reports.size();
    end
  end

endmodule

// ===== verif/ultrasonic_echo_ranger_tb.sv =====
// Testbench top: clock, reset, stimulus, register phases and verdict for the echo ranger.
module ultrasonic_echo_ranger_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import uer_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNKNOWN = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int IDLE_PCT    = 17;
  localparam int NUM_PHASES  = 7;
  localparam int PHASE_ITEMS = 235;
  localparam int CALM_PHASE  = 3;

  logic                     clk_i        = 1'b0;
  logic                     rst_ni       = 1'b0;
  logic                     in_valid_i   = 1'b0;
  logic [FUNC_W-1:0]        func_i       = '0;
  logic [TIME_W-1:0]        now_us_i     = '0;
  logic signed [TEMP_W-1:0] temp_centi_i = '0;
  logic                     out_stall_i  = 1'b0;
  logic                     cfg_valid_i  = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index_i  = CFG_TIMEOUT;
  logic [CFG_DAT_W-1:0]     cfg_data_i   = '0;

  logic                in_stall_o;
  logic                out_valid_o;
  logic                trigger_o;
  logic [MODE_W-1:0]   mode_o;
  logic [DIST_W-1:0]   avg_distance_um_o;
  logic [DIST_W-1:0]   last_distance_um_o;
  logic                measured_o;
  logic                failed_o;
  logic                recalibrate_o;
  logic [HEALTH_W-1:0] health_o;
  logic                prefer_ultrasonic_o;
  logic                cfg_ready_o;

  int fail_count;
  int pending;
  int checked;
  int distance_count;
  int error_count;
  int recal_count;

  int          cycle_count = 0;
  int          items_sent  = 0;
  int          cfg_writes  = 0;
  bit          calm        = 1'b0;
  int unsigned limit_cfg   = 29411;
  int unsigned range_cfg   = 5000000;
  logic [31:0] stamp;

  ultrasonic_echo_ranger dut (.*);

  ultrasonic_echo_ranger_checker checker_i (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_i          (in_stall_o),
    .func_i              (func_i),
    .now_us_i            (now_us_i),
    .temp_centi_i        (temp_centi_i),
    .out_valid_i         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .trigger_i           (trigger_o),
    .mode_i              (mode_o),
    .avg_distance_um_i   (avg_distance_um_o),
    .last_distance_um_i  (last_distance_um_o),
    .measured_i          (measured_o),
    .failed_i            (failed_o),
    .recalibrate_i       (recalibrate_o),
    .health_i            (health_o),
    .prefer_ultrasonic_i (prefer_ultrasonic_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_i         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .fail_count_o        (fail_count),
    .pending_o           (pending),
    .checked_o           (checked),
    .distance_count_o    (distance_count),
    .error_count_o       (error_count),
    .recal_count_o       (recal_count)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("FAIL ultrasonic_echo_ranger");
      $finish;
    end
  end

  function automatic logic signed [TEMP_W-1:0] rand_temp();
    if ($urandom_range(0, 99) < 85) return TEMP_W'(int'($urandom_range(0, 12500)) - 4000);
    return TEMP_W'($urandom_range(0, 32767));
  endfunction

  function automatic logic [31:0] pick_span();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return $urandom_range(0, range_cfg / 140 + 1);
  endfunction

  task automatic send_item(input logic [FUNC_W-1:0] code, input logic [TIME_W-1:0] t,
                           input logic signed [TEMP_W-1:0] temp);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    func_i       <= code;
    now_us_i     <= t;
    temp_centi_i <= temp;
    do @(posedge clk_i); while (in_stall_o);
    if (code != FUNC_UNKNOWN) items_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DAT_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    cfg_writes++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic echo_and_close(input logic [31:0] span);
    stamp += $urandom_range(0, 100);
    send_item(FUNC_RISE, stamp, rand_temp());
    stamp += span;
    send_item(FUNC_FALL, stamp, rand_temp());
    stamp += $urandom_range(0, 50);
    send_item(FUNC_TICK, stamp, rand_temp());
  endtask

  task automatic rest_and_trigger();
    send_item(FUNC_TICK, stamp, rand_temp());
    if ($urandom_range(0, 3) == 0) send_item(FUNC_TICK, stamp + limit_cfg, rand_temp());
    stamp += limit_cfg + 1 + $urandom_range(0, 3);
    send_item(FUNC_TICK, stamp, rand_temp());
    stamp += $urandom_range(1, 20);
    send_item(FUNC_TICK, stamp, rand_temp());
  endtask

  task automatic echo_timeout();
    logic [31:0] trig_stamp;
    rest_and_trigger();
    trig_stamp = stamp;
    if ($urandom_range(0, 1) == 1) begin
      send_item(FUNC_RISE, trig_stamp + $urandom_range(0, limit_cfg), rand_temp());
    end
    send_item(FUNC_TICK, trig_stamp + limit_cfg, rand_temp());
    stamp = trig_stamp + limit_cfg + 1 + $urandom_range(0, 5);
    send_item(FUNC_TICK, stamp, rand_temp());
    stamp += 1;
    send_item(FUNC_TICK, stamp, rand_temp());
  endtask

  task automatic line_noise();
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(0, 7) == 0) stamp = $urandom;
      else stamp += $urandom_range(0, 2 * limit_cfg);
      send_item(FUNC_W'($urandom_range(0, 3)), stamp, TEMP_W'($urandom_range(0, 32767)));
    end
  endtask

  initial begin
    logic [31:0] trig_stamp;
    int          goal;
    int          pick;
    int unsigned thr_cfg;

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    stamp = 32'hFFFF_F000;
    send_item(FUNC_UNKNOWN, 32'hFFFF_FFFF, 15'h4000);
    send_item(FUNC_TICK, stamp, 15'h3FFF);
    send_item(FUNC_TICK, stamp + limit_cfg, 15'd0);
    send_item(FUNC_TICK, stamp + limit_cfg + 1, 15'd0);
    trig_stamp = stamp + limit_cfg + 2;
    send_item(FUNC_TICK, trig_stamp, 15'd0);
    send_item(FUNC_TICK, trig_stamp + 100, 15'd0);
    send_item(FUNC_RISE, trig_stamp + 200, 15'h4000);
    send_item(FUNC_TICK, trig_stamp + limit_cfg, 15'd0);
    send_item(FUNC_FALL, trig_stamp + 1200, 15'h3FFF);
    send_item(FUNC_TICK, trig_stamp + 1300, 15'h4000);
    send_item(FUNC_RISE, 32'd0, 15'd0);
    send_item(FUNC_FALL, 32'd0, 15'd0);
    send_item(FUNC_TICK, 32'd5, 15'h3FFF);
    send_item(FUNC_RISE, 32'd0, 15'd0);
    send_item(FUNC_FALL, 32'hFFFF_FFFF, 15'd0);
    send_item(FUNC_TICK, 32'd10, 15'h3FFF);
    send_item(FUNC_TICK, 32'd20, 15'd0);
    send_item(FUNC_TICK, 32'd1000, 15'd0);
    send_item(FUNC_RISE, 32'd1001, 15'd0);
    send_item(FUNC_FALL, 32'd1501, 15'd0);
    send_item(FUNC_TICK, 32'd1502, 15'd0);
    send_item(FUNC_TICK, 32'd1000 + limit_cfg + 1, 15'd0);
    send_item(FUNC_TICK, 32'd40000, 15'd0);
    send_item(FUNC_TICK, 32'd40000 + limit_cfg + 1, 15'd0);
    send_item(FUNC_TICK, 32'd70000, 15'd0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      case (p)
        0: begin limit_cfg = 29411;   range_cfg = 5000000;  thr_cfg = 90;  end
        1: begin limit_cfg = 1;       range_cfg = 16777215; thr_cfg = 0;   end
        2: begin limit_cfg = 1048575; range_cfg = 1;        thr_cfg = 127; end
        3: begin limit_cfg = 1000000; range_cfg = 10000000; thr_cfg = 100; end
        4: begin limit_cfg = 500;     range_cfg = 300000;   thr_cfg = 50;  end
        default: begin
          limit_cfg = $urandom_range(1, 1000000);
          range_cfg = $urandom_range(1, 10000000);
          thr_cfg   = $urandom_range(0, 100);
        end
      endcase
      write_reg(CFG_TIMEOUT, CFG_DAT_W'(limit_cfg));
      write_reg(CFG_MAX_RANGE, CFG_DAT_W'(range_cfg));
      write_reg(CFG_HEALTH_THR, CFG_DAT_W'(thr_cfg));
      calm  = (p == CALM_PHASE);
      stamp = 32'hFFFF_FFFF - $urandom_range(0, 3000000);
      goal  = items_sent + PHASE_ITEMS;
      while (items_sent < goal) begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          echo_and_close(pick_span());
        end else if (pick < 75) begin
          rest_and_trigger();
          echo_and_close(pick_span());
        end else if (pick < 83) begin
          echo_timeout();
        end else begin
          line_noise();
        end
      end
    end
    calm = 1'b0;

    drain();
    repeat (20) @(negedge clk_i);
    $display("Checked %0d results across %0d register writes and %0d settings",
             checked, cfg_writes, NUM_PHASES + 1);
    $display("  %0d distances accepted, %0d errors handled, %0d recalibrations",
             distance_count, error_count, recal_count);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS ultrasonic_echo_ranger");
    end else begin
      $display("FAIL ultrasonic_echo_ranger");
    end
    $finish;
  end

endmodule
